/* rtl/ptts_pkg.sv */
// Package for the periodic task tick scheduler.
// Holds sizes, command and result codes, the sequencer state type and the
// structs passed between modules. No dependencies.
package ptts_pkg;

    localparam int NUM_TASKS = 8;
    localparam int SLOT_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);
    localparam int CMP_W     = 8;
    localparam int TIME_W    = 16;
    localparam int MEM_W     = 2 * TIME_W;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CREATE  = 3'd1;
    localparam logic [2:0] CMD_SUSPEND = 3'd2;
    localparam logic [2:0] CMD_RESUME  = 3'd3;
    localparam logic [2:0] CMD_DELETE  = 3'd4;

    localparam logic [1:0] KIND_STATUS    = 2'd0;
    localparam logic [1:0] KIND_DUE       = 2'd1;
    localparam logic [1:0] KIND_TICK_IDLE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [2:0]        task_slot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] first_delay;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] due_slot;
        logic       status;
        logic       last;
    } res_t;

endpackage

/* rtl/ptts_sched_core.sv */
// Scheduler core: task table memory (period and countdown), occupied and
// running flags, and the sequencer that walks the table on a tick.
// Depends on ptts_pkg.
module ptts_sched_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_vld,
    output logic          in_ready,
    input  ptts_pkg::cmd_t in_cmd,
    output logic          push_vld,
    input  logic          push_ready,
    output ptts_pkg::res_t push
);
    import ptts_pkg::*;

    // Each entry holds {period, countdown}.
    logic [MEM_W-1:0] mem [NUM_TASKS];
    logic [MEM_W-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [NUM_TASKS-1:0] used_reg;
    logic [NUM_TASKS-1:0] run_reg;
    logic                 status_reg;
    logic [CNT_W-1:0]     issue_idx_reg;
    logic                 proc_vld_reg;
    logic [SLOT_W-1:0]    proc_idx_reg;
    logic                 hold_vld_reg;
    logic [SLOT_W-1:0]    hold_slot_reg;

    logic              accept;
    logic              in_range;
    logic [SLOT_W-1:0] cmd_idx;
    logic              create_ok;
    logic              walk_done;
    logic              active;
    logic              due;
    logic              stall;
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [MEM_W-1:0]  wr_data;
    logic [TIME_W-1:0] cd_val;
    logic [TIME_W-1:0] per_val;
    logic [TIME_W-1:0] new_cd;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_vld && in_ready;
    assign in_range  = CMP_W'(in_cmd.task_slot) < CMP_W'(NUM_TASKS);
    assign cmd_idx   = SLOT_W'(in_cmd.task_slot);
    assign create_ok = (in_cmd.command == CMD_CREATE) && in_range && !used_reg[cmd_idx];
    assign walk_done = (issue_idx_reg == CNT_W'(NUM_TASKS)) && !proc_vld_reg;

    assign per_val = rd_data_reg[MEM_W-1:TIME_W];
    assign cd_val  = rd_data_reg[TIME_W-1:0];
    assign active  = proc_vld_reg && used_reg[proc_idx_reg] && run_reg[proc_idx_reg];
    assign due     = active && (cd_val == '0);
    // A zero period behaves as one, so the reload value is zero in both cases.
    assign new_cd  = due ? ((per_val == '0) ? '0 : per_val - TIME_W'(1))
                         : cd_val - TIME_W'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (in_cmd.command == CMD_TICK) ? ST_WALK : ST_STATUS;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH, ST_STATUS: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        push_vld = 1'b0;
        push     = '0;
        stall    = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = proc_idx_reg;
        wr_data  = {per_val, new_cd};
        case (state_reg)
            ST_IDLE: begin
                wr_en   = accept && create_ok;
                wr_addr = cmd_idx;
                wr_data = {in_cmd.period, in_cmd.first_delay};
            end
            ST_WALK: begin
                // A new due slot pushes out the one held before it; the held
                // one is not the final result of this tick.
                push_vld      = due && hold_vld_reg;
                push.kind     = KIND_DUE;
                push.due_slot = 3'(hold_slot_reg);
                stall         = push_vld && !push_ready;
                rd_en         = (issue_idx_reg != CNT_W'(NUM_TASKS)) && !stall;
                wr_en         = active && !stall;
            end
            ST_FLUSH: begin
                push_vld      = 1'b1;
                push.kind     = hold_vld_reg ? KIND_DUE : KIND_TICK_IDLE;
                push.due_slot = hold_vld_reg ? 3'(hold_slot_reg) : 3'd0;
                push.last     = 1'b1;
            end
            ST_STATUS: begin
                push_vld    = 1'b1;
                push.kind   = KIND_STATUS;
                push.status = status_reg;
                push.last   = 1'b1;
            end
            default: begin
                push_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[issue_idx_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            run_reg       <= '0;
            status_reg    <= 1'b0;
            issue_idx_reg <= '0;
            proc_vld_reg  <= 1'b0;
            proc_idx_reg  <= '0;
            hold_vld_reg  <= 1'b0;
            hold_slot_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                issue_idx_reg <= '0;
                status_reg    <= (in_cmd.command == CMD_CREATE) && !create_ok;
                if (create_ok) begin
                    used_reg[cmd_idx] <= 1'b1;
                    run_reg[cmd_idx]  <= 1'b1;
                end else if (in_range) begin
                    case (in_cmd.command)
                        CMD_SUSPEND: run_reg[cmd_idx]  <= 1'b0;
                        CMD_RESUME:  run_reg[cmd_idx]  <= 1'b1;
                        CMD_DELETE:  used_reg[cmd_idx] <= 1'b0;
                        default: begin
                        end
                    endcase
                end
            end
            if (state_reg == ST_WALK && !stall) begin
                proc_vld_reg <= rd_en;
                proc_idx_reg <= issue_idx_reg[SLOT_W-1:0];
                if (rd_en) begin
                    issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                end
                if (due) begin
                    hold_vld_reg  <= 1'b1;
                    hold_slot_reg <= proc_idx_reg;
                end
            end
            if (state_reg == ST_FLUSH && push_ready) begin
                hold_vld_reg <= 1'b0;
            end
        end
    end

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !proc_vld_reg && !hold_vld_reg)
        else $error("sequencer idle with a slot or due result still pending");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && stall) |=> proc_vld_reg && $stable(proc_idx_reg)
            && $stable(rd_data_reg))
        else $error("stalled slot lost its read data");

    a_idle_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_vld && push.kind == KIND_TICK_IDLE) |-> !hold_vld_reg && push.last)
        else $error("nothing-due result issued while a due slot is held");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_idx_reg <= CNT_W'(NUM_TASKS))
        else $error("slot walk ran past the table");

endmodule

/* rtl/ptts_out_reg.sv */
// Output register stage for result transactions; lets the core finish
// its next step while a result waits on the downstream side.
// Depends on ptts_pkg.
module ptts_out_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_vld,
    output logic           push_ready,
    input  ptts_pkg::res_t push,
    output logic           out_vld,
    input  logic           out_ready,
    output ptts_pkg::res_t out_res
);
    import ptts_pkg::*;

    logic vld_reg;
    res_t res_reg;

    assign push_ready = !vld_reg || out_ready;
    assign out_vld    = vld_reg;
    assign out_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (push_ready) begin
            vld_reg <= push_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ready && push_vld) begin
            res_reg <= push;
        end
    end

endmodule

/* rtl/periodic_task_tick_scheduler_top.sv */
// Periodic task tick scheduler, top level.
// A command's status result is issued from the status state through the output register; a tick
// walks the table one slot per cycle from one memory read port, pausing while a due result
// waits on the output, and its final result is issued from the flush state.
// One transaction at a time: a new command is taken only once the last result is pushed.
// Reset (aresetn, synchronous, active low) clears all occupied and running
// flags; period and countdown entries hold no value until a task is created.
module periodic_task_tick_scheduler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // task_slot[2:0], period[18:3], first_delay[34:19]
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // due_slot[2:0], status[3]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import ptts_pkg::*;

    cmd_t in_cmd;
    res_t push;
    res_t out_res;
    logic push_vld;
    logic push_ready;

    assign in_cmd.command     = s_tuser;
    assign in_cmd.task_slot   = s_tdata[2:0];
    assign in_cmd.period      = s_tdata[18:3];
    assign in_cmd.first_delay = s_tdata[34:19];

    ptts_sched_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_vld     (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (in_cmd),
        .push_vld   (push_vld),
        .push_ready (push_ready),
        .push       (push)
    );

    ptts_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_vld   (push_vld),
        .push_ready (push_ready),
        .push       (push),
        .out_vld    (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = {4'b0000, out_res.status, out_res.due_slot};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

/* tb/sv/periodic_task_tick_scheduler_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for periodic_task_tick_scheduler_top.
// Depends on ptts_pkg and the top level; keeps its own copy of the task table
// to predict every due, idle-tick and status transaction.
module periodic_task_tick_scheduler_top_tb;
    import ptts_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int IDLE_PCT    = 9;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CMDS = 175;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // task_slot[2:0], period[18:3], first_delay[34:19]
    logic [2:0]  s_tuser  = '0;   // command[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // due_slot[2:0], status[3]
    logic [1:0]  m_tuser;         // kind[1:0]
    logic        m_tlast;

    // Shadow copy of the scheduler's task table.
    logic              tbl_used   [NUM_TASKS];
    logic              tbl_run    [NUM_TASKS];
    logic [TIME_W-1:0] tbl_period [NUM_TASKS];
    logic [TIME_W-1:0] tbl_count  [NUM_TASKS];

    res_t        pending_reports[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          steady_flow    = 1'b0;

    periodic_task_tick_scheduler_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("periodic_task_tick_scheduler_top_tb: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Applies one command to the shadow table and queues the results it causes.
    function automatic void schedule_step(input logic [2:0] cmd, input logic [2:0] slot,
                                          input logic [TIME_W-1:0] per,
                                          input logic [TIME_W-1:0] dly);
        logic [NUM_TASKS-1:0] due_mask;
        logic [TIME_W-1:0]    reload;
        res_t                 rpt;
        int                   i;
        int                   top_due;
        due_mask = '0;
        top_due  = -1;
        rpt      = '0;
        if (cmd == CMD_TICK) begin
            for (i = 0; i < NUM_TASKS; i++) begin
                if (tbl_used[i] && tbl_run[i]) begin
                    if (tbl_count[i] == '0) begin
                        reload       = (tbl_period[i] == '0) ? 16'd1 : tbl_period[i];
                        tbl_count[i] = reload - 16'd1;
                        due_mask[i]  = 1'b1;
                        top_due      = i;
                    end else begin
                        tbl_count[i] = tbl_count[i] - 16'd1;
                    end
                end
            end
            if (top_due < 0) begin
                rpt.kind = KIND_TICK_IDLE;
                rpt.last = 1'b1;
                pending_reports.push_back(rpt);
            end else begin
                for (i = 0; i < NUM_TASKS; i++) begin
                    if (due_mask[i]) begin
                        rpt.kind     = KIND_DUE;
                        rpt.due_slot = i[2:0];
                        rpt.last     = (i == top_due);
                        pending_reports.push_back(rpt);
                    end
                end
            end
        end else begin
            rpt.kind = KIND_STATUS;
            rpt.last = 1'b1;
            case (cmd)
                CMD_CREATE: begin
                    if (tbl_used[slot]) begin
                        rpt.status = 1'b1;
                    end else begin
                        tbl_period[slot] = per;
                        tbl_count[slot]  = dly;
                        tbl_used[slot]   = 1'b1;
                        tbl_run[slot]    = 1'b1;
                    end
                end
                CMD_SUSPEND: tbl_run[slot]  = 1'b0;
                CMD_RESUME:  tbl_run[slot]  = 1'b1;
                CMD_DELETE:  tbl_used[slot] = 1'b0;
                default: ;
            endcase
            pending_reports.push_back(rpt);
        end
    endfunction

    // Offers one command; valid stays high after acceptance unless a gap follows.
    task automatic send_cmd(input logic [2:0] cmd, input logic [2:0] slot,
                            input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] dly);
        if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, dly, per, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        schedule_step(cmd, slot, per, dly);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual kind %0d slot %0d status %0d last %0d",
                         $time, m_tuser, m_tdata[2:0], m_tdata[3], m_tlast);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("due_slot", want.due_slot, m_tdata[2:0]);
                check_field("status", want.status, m_tdata[3]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // Small values keep tasks firing; now and then the whole 16-bit range.
    function automatic logic [TIME_W-1:0] pick_ticks(input int unsigned span);
        if ($urandom_range(99) < 15) begin
            return TIME_W'($urandom_range(16'hFFFF));
        end
        return TIME_W'($urandom_range(span));
    endfunction

    task automatic test_empty_tick();
        send_cmd(CMD_TICK, 3'd0, '0, '0);
        wait_drained();
    endtask

    task automatic test_create_busy();
        send_cmd(CMD_CREATE, 3'd0, 16'd0, 16'd0);
        send_cmd(CMD_CREATE, 3'd0, 16'd5, 16'd5);
        send_cmd(CMD_CREATE, 3'd7, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_TICK, 3'd7, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_TICK, 3'd0, '0, '0);
        wait_drained();
    endtask

    task automatic test_run_control();
        send_cmd(CMD_SUSPEND, 3'd0, '0, '0);
        send_cmd(CMD_TICK, 3'd0, '0, '0);
        send_cmd(CMD_RESUME, 3'd0, '0, '0);
        send_cmd(CMD_TICK, 3'd0, '0, '0);
        send_cmd(CMD_DELETE, 3'd0, '0, '0);
        send_cmd(CMD_TICK, 3'd0, '0, '0);
        // Resuming a free slot must not bring it into the walk.
        send_cmd(CMD_RESUME, 3'd3, '0, '0);
        send_cmd(CMD_TICK, 3'd0, '0, '0);
        send_cmd(CMD_DELETE, 3'd7, '0, '0);
        wait_drained();
    endtask

    task automatic test_unknown_commands();
        int c;
        for (c = int'(CMD_DELETE) + 1; c < 8; c++) begin
            send_cmd(c[2:0], 3'($urandom_range(7)), 16'($urandom), 16'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_all_slots_due();
        int s;
        for (s = 0; s < NUM_TASKS; s++) begin
            send_cmd(CMD_CREATE, s[2:0], 16'd0, 16'd0);
        end
        send_cmd(CMD_TICK, 3'd0, '0, '0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int          n;
        int unsigned pick;
        logic [2:0]  cmd;
        for (n = 0; n < RANDOM_CMDS; n++) begin
            steady_flow = (n >= 60 && n < 110);
            if (n == 130) begin
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                cmd = CMD_TICK;
            end else if (pick < 65) begin
                cmd = CMD_CREATE;
            end else if (pick < 74) begin
                cmd = CMD_SUSPEND;
            end else if (pick < 83) begin
                cmd = CMD_RESUME;
            end else if (pick < 96) begin
                cmd = CMD_DELETE;
            end else begin
                cmd = CMD_DELETE + 3'd1 + 3'($urandom_range(2));
            end
            send_cmd(cmd, 3'($urandom_range(7)), pick_ticks(4), pick_ticks(6));
        end
        steady_flow = 1'b0;
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            tbl_used[i]   = 1'b0;
            tbl_run[i]    = 1'b0;
            tbl_period[i] = '0;
            tbl_count[i]  = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_tick();
        test_create_busy();
        test_run_control();
        test_unknown_commands();
        test_all_slots_due();
        test_random_traffic();

        repeat (NUM_TASKS + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("periodic_task_tick_scheduler_top_tb: clean");
        end else begin
            $display("periodic_task_tick_scheduler_top_tb: errors");
        end
        $finish;
    end

endmodule
